### src/sfcp_pkg.sv
// sfcp_pkg: shared types and codes for the serial frame and command parser
// no dependencies; imported by sfcp_step, serial_frame_and_command_parser and the bench
package sfcp_pkg;

	// parse phases
	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_FHEAD    = 4'd1;
	localparam logic [3:0] PH_LSTART   = 4'd2;
	localparam logic [3:0] PH_DHEAD    = 4'd3;
	localparam logic [3:0] PH_LEN      = 4'd4;
	localparam logic [3:0] PH_BODY     = 4'd5;
	localparam logic [3:0] PH_LINE     = 4'd6;
	localparam logic [3:0] PH_LINE_END = 4'd7;
	localparam logic [3:0] PH_DCMD     = 4'd8;

	// event codes
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_OK      = 3'd1;
	localparam logic [2:0] EV_BADSUM  = 3'd2;
	localparam logic [2:0] EV_BADLEN  = 3'd3;
	localparam logic [2:0] EV_LINE    = 3'd4;
	localparam logic [2:0] EV_LINEOVF = 3'd5;
	localparam logic [2:0] EV_DEBUG   = 3'd6;

	// byte kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_FRAME = 2'd1;
	localparam logic [1:0] KIND_LINE  = 2'd2;
	localparam logic [1:0] KIND_DEBUG = 2'd3;

	// register indexes
	localparam logic [2:0] REG_FRAME_HEAD_FIRST  = 3'd0;
	localparam logic [2:0] REG_FRAME_HEAD_SECOND = 3'd1;
	localparam logic [2:0] REG_DEBUG_HEAD_FIRST  = 3'd2;
	localparam logic [2:0] REG_DEBUG_HEAD_SECOND = 3'd3;
	localparam logic [2:0] REG_LINE_START_BYTE   = 3'd4;
	localparam logic [2:0] REG_LINE_END_BYTE     = 3'd5;
	localparam logic [2:0] REG_MAX_FRAME_LENGTH  = 3'd6;
	localparam logic [2:0] REG_MAX_LINE_LENGTH   = 3'd7;

	// register reset values
	localparam logic [7:0] RST_LINE_START = 8'd13;
	localparam logic [7:0] RST_LINE_END   = 8'd10;
	localparam logic [7:0] RST_MAX_FRAME  = 8'd80;
	localparam logic [6:0] RST_MAX_LINE   = 7'd50;

	// shortest binary frame
	localparam logic [7:0] MIN_FRAME_LEN = 8'd3;

	typedef struct packed {
		logic [7:0] frame_head_first;
		logic [7:0] frame_head_second;
		logic [7:0] debug_head_first;
		logic [7:0] debug_head_second;
		logic [7:0] line_start_byte;
		logic [7:0] line_end_byte;
		logic [7:0] max_frame_length;
		logic [6:0] max_line_length;
	} cfg_t;

	typedef struct packed {
		logic [3:0] phase;
		logic [7:0] expected_length;
		logic [7:0] bytes_seen;
		logic [7:0] running_xor;
	} parse_state_t;

	typedef struct packed {
		logic [7:0] echo_byte;
		logic [1:0] byte_kind;
		logic [7:0] byte_position;
		logic [2:0] frame_event;
	} result_t;

endpackage

### src/serial_frame_and_command_parser.sv
// serial_frame_and_command_parser: top level, config registers, parse state, result register
// depends on sfcp_pkg and sfcp_step
//
//   channel  signals                                  direction
//   rx       rx_valid, rx_stall, rx_byte              byte in
//   res      res_valid, res_stall, echo_byte,         tagged byte out
//            byte_kind, byte_position, frame_event
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// one byte per cycle while rx_stall is low: each accepted byte is parsed in the accept
// cycle and its tagged result lands in the output register, visible the next cycle.
// rx_stall is raised only while a result is held and res_stall is high.
// arst_n clears the parse state, the output valid and loads register defaults.
// cfg_ready is always high.
module serial_frame_and_command_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] echo_byte,
	output logic [1:0] byte_kind,
	output logic [7:0] byte_position,
	output logic [2:0] frame_event,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import sfcp_pkg::*;

	cfg_t         cfg_q;
	parse_state_t state_q;
	parse_state_t state_nxt;
	result_t      step_res;
	result_t      res_q;
	logic         res_valid_q;
	logic         rx_accept;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_head_first  <= 8'd0;
			cfg_q.frame_head_second <= 8'd0;
			cfg_q.debug_head_first  <= 8'd0;
			cfg_q.debug_head_second <= 8'd0;
			cfg_q.line_start_byte   <= RST_LINE_START;
			cfg_q.line_end_byte     <= RST_LINE_END;
			cfg_q.max_frame_length  <= RST_MAX_FRAME;
			cfg_q.max_line_length   <= RST_MAX_LINE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_HEAD_FIRST:  cfg_q.frame_head_first  <= cfg_data;
				REG_FRAME_HEAD_SECOND: cfg_q.frame_head_second <= cfg_data;
				REG_DEBUG_HEAD_FIRST:  cfg_q.debug_head_first  <= cfg_data;
				REG_DEBUG_HEAD_SECOND: cfg_q.debug_head_second <= cfg_data;
				REG_LINE_START_BYTE:   cfg_q.line_start_byte   <= cfg_data;
				REG_LINE_END_BYTE:     cfg_q.line_end_byte     <= cfg_data;
				REG_MAX_FRAME_LENGTH:  cfg_q.max_frame_length  <= cfg_data;
				REG_MAX_LINE_LENGTH:   cfg_q.max_line_length   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// input beat taken when the output register is free or draining
	assign rx_stall  = res_valid_q & res_stall;
	assign rx_accept = rx_valid & ~rx_stall;

	sfcp_step u_step (
		.cfg     (cfg_q),
		.cur     (state_q),
		.rx_byte (rx_byte),
		.nxt     (state_nxt),
		.res     (step_res)
	);

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (rx_accept) begin
			state_q <= state_nxt;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rx_accept) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (rx_accept) begin
			res_q <= step_res;
		end
	end

	assign res_valid     = res_valid_q;
	assign echo_byte     = res_q.echo_byte;
	assign byte_kind     = res_q.byte_kind;
	assign byte_position = res_q.byte_position;
	assign frame_event   = res_q.frame_event;

endmodule

### src/sfcp_step.sv
// sfcp_step: next-state and tag logic for one received byte
// depends on sfcp_pkg
module sfcp_step (
	input  sfcp_pkg::cfg_t         cfg,
	input  sfcp_pkg::parse_state_t cur,
	input  logic [7:0]             rx_byte,
	output sfcp_pkg::parse_state_t nxt,
	output sfcp_pkg::result_t      res
);
	import sfcp_pkg::*;

	logic [8:0] body_next;
	logic [7:0] line_count;

	// frame end test and line body count
	assign body_next  = {1'b0, cur.bytes_seen} + 9'd1;
	assign line_count = cur.bytes_seen + 8'd1;

	// one byte through the parser
	always_comb begin
		nxt               = cur;
		res.echo_byte     = rx_byte;
		res.byte_kind     = KIND_NONE;
		res.byte_position = 8'd0;
		res.frame_event   = EV_NONE;
		case (cur.phase)
			PH_FHEAD: begin
				if (rx_byte == cfg.frame_head_second) begin
					res.byte_kind     = KIND_FRAME;
					res.byte_position = 8'd1;
					nxt.running_xor   = cur.running_xor ^ rx_byte;
					nxt.phase         = PH_LEN;
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
			PH_LSTART: begin
				if (rx_byte == cfg.line_end_byte) begin
					nxt.bytes_seen = 8'd0;
					nxt.phase      = PH_LINE;
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
			PH_DHEAD: begin
				if (rx_byte == cfg.debug_head_second) begin
					res.byte_kind     = KIND_DEBUG;
					res.byte_position = 8'd1;
					nxt.phase         = PH_DCMD;
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
			PH_LEN: begin
				res.byte_kind       = KIND_FRAME;
				res.byte_position   = 8'd2;
				nxt.expected_length = rx_byte;
				if (rx_byte > cfg.max_frame_length || rx_byte < MIN_FRAME_LEN) begin
					res.frame_event = EV_BADLEN;
					nxt.phase       = PH_IDLE;
				end else if (rx_byte == MIN_FRAME_LEN) begin
					// length byte doubles as checksum
					res.frame_event = (rx_byte == cur.running_xor) ? EV_OK : EV_BADSUM;
					nxt.phase       = PH_IDLE;
				end else begin
					nxt.running_xor = cur.running_xor ^ rx_byte;
					nxt.bytes_seen  = MIN_FRAME_LEN;
					nxt.phase       = PH_BODY;
				end
			end
			PH_BODY: begin
				res.byte_kind     = KIND_FRAME;
				res.byte_position = cur.bytes_seen;
				if (body_next >= {1'b0, cur.expected_length}) begin
					res.frame_event = (rx_byte == cur.running_xor) ? EV_OK : EV_BADSUM;
					nxt.phase       = PH_IDLE;
				end else begin
					nxt.running_xor = cur.running_xor ^ rx_byte;
					nxt.bytes_seen  = body_next[7:0];
				end
			end
			PH_LINE: begin
				res.byte_position = cur.bytes_seen;
				if (rx_byte == cfg.line_start_byte) begin
					nxt.phase = PH_LINE_END;
				end else begin
					res.byte_kind  = KIND_LINE;
					nxt.bytes_seen = line_count;
					if (line_count >= {1'b0, cfg.max_line_length}) begin
						res.frame_event = EV_LINEOVF;
						nxt.phase       = PH_IDLE;
					end
				end
			end
			PH_LINE_END: begin
				res.byte_position = cur.bytes_seen;
				if (rx_byte == cfg.line_end_byte) begin
					// empty line keeps collecting
					if (cur.bytes_seen == 8'd0) begin
						nxt.phase = PH_LINE;
					end else begin
						res.frame_event = EV_LINE;
						nxt.phase       = PH_IDLE;
					end
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
			PH_DCMD: begin
				res.byte_kind     = KIND_DEBUG;
				res.byte_position = 8'd2;
				res.frame_event   = EV_DEBUG;
				nxt.phase         = PH_IDLE;
			end
			default: begin
				// idle: frame header wins over line start, then debug header
				if (rx_byte == cfg.frame_head_first) begin
					res.byte_kind   = KIND_FRAME;
					nxt.running_xor = rx_byte;
					nxt.phase       = PH_FHEAD;
				end else if (rx_byte == cfg.line_start_byte) begin
					nxt.phase = PH_LSTART;
				end else if (rx_byte == cfg.debug_head_first) begin
					res.byte_kind = KIND_DEBUG;
					nxt.phase     = PH_DHEAD;
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
		endcase
	end

endmodule

### bench/serial_frame_and_command_parser_tb.sv
`timescale 1ns / 100ps
// serial_frame_and_command_parser_tb: self-checking bench for the serial frame and command parser
// streams frames, lines, debug commands and noise through random idling, checks every tagged beat
// depends on sfcp_pkg and serial_frame_and_command_parser
module serial_frame_and_command_parser_tb;
	import sfcp_pkg::*;

	localparam int CLK_HALF = 2;
	localparam int RUN_LIMIT_NS = 4000000;
	localparam int LONG_HOLD = 200;
	localparam int PHASE_BYTES = 250;
	localparam int PHASE_COUNT = 7;
	localparam int MAX_REPORTS = 40;
	localparam int DRAIN_CYCLES = 4;
	localparam logic [7:0] FIRST_BODY_POS = 8'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       rx_valid = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte = 8'd0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] echo_byte;
	logic [1:0] byte_kind;
	logic [7:0] byte_position;
	logic [2:0] frame_event;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = 3'd0;
	logic [7:0] cfg_data = 8'd0;

	// bench copy of the registers and the parse state
	cfg_t cfg_now = '{8'd0, 8'd0, 8'd0, 8'd0, RST_LINE_START, RST_LINE_END,
		RST_MAX_FRAME, RST_MAX_LINE};
	parse_state_t track = '{PH_IDLE, 8'd0, 8'd0, 8'd0};

	logic [7:0]  rx_bytes_q[$];
	result_t     tags_due[$];
	result_t     tag_want;
	int unsigned bytes_queued = 0;
	int unsigned tags_checked = 0;
	int unsigned mismatch_count = 0;

	int unsigned rx_gap_pct = 0;
	int unsigned res_stall_pct = 0;
	int unsigned rx_gap_left = 0;
	int unsigned res_hold_left = 0;
	bit          long_hold_req = 1'b0;
	bit          long_hold_done = 1'b0;

	int unsigned gap_plan[PHASE_COUNT] = '{30, 0, 50, 10, 0, 20, 40};
	int unsigned stall_plan[PHASE_COUNT] = '{30, 0, 10, 50, 5, 20, 40};

	serial_frame_and_command_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.echo_byte(echo_byte),
		.byte_kind(byte_kind),
		.byte_position(byte_position),
		.frame_event(frame_event),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// tag one received byte and advance the parse state
	function automatic result_t tag_byte(input logic [7:0] b);
		result_t t;
		t.echo_byte = b;
		t.byte_kind = KIND_NONE;
		t.byte_position = 8'd0;
		t.frame_event = EV_NONE;
		case (track.phase)
			PH_FHEAD: begin
				if (b == cfg_now.frame_head_second) begin
					t.byte_kind = KIND_FRAME;
					t.byte_position = 8'd1;
					track.running_xor = track.running_xor ^ b;
					track.phase = PH_LEN;
				end else begin
					track.phase = PH_IDLE;
				end
			end
			PH_LSTART: begin
				if (b == cfg_now.line_end_byte) begin
					track.bytes_seen = 8'd0;
					track.phase = PH_LINE;
				end else begin
					track.phase = PH_IDLE;
				end
			end
			PH_DHEAD: begin
				if (b == cfg_now.debug_head_second) begin
					t.byte_kind = KIND_DEBUG;
					t.byte_position = 8'd1;
					track.phase = PH_DCMD;
				end else begin
					track.phase = PH_IDLE;
				end
			end
			PH_LEN: begin
				t.byte_kind = KIND_FRAME;
				t.byte_position = 8'd2;
				track.expected_length = b;
				if (b > cfg_now.max_frame_length || b < MIN_FRAME_LEN) begin
					t.frame_event = EV_BADLEN;
					track.phase = PH_IDLE;
				end else if (b == MIN_FRAME_LEN) begin
					// shortest frame: the length byte doubles as checksum
					t.frame_event = (b == track.running_xor) ? EV_OK : EV_BADSUM;
					track.phase = PH_IDLE;
				end else begin
					track.running_xor = track.running_xor ^ b;
					track.bytes_seen = FIRST_BODY_POS;
					track.phase = PH_BODY;
				end
			end
			PH_BODY: begin
				t.byte_kind = KIND_FRAME;
				t.byte_position = track.bytes_seen;
				if ({1'b0, track.bytes_seen} + 9'd1 >= {1'b0, track.expected_length}) begin
					t.frame_event = (b == track.running_xor) ? EV_OK : EV_BADSUM;
					track.phase = PH_IDLE;
				end else begin
					track.running_xor = track.running_xor ^ b;
					track.bytes_seen = track.bytes_seen + 8'd1;
				end
			end
			PH_LINE: begin
				t.byte_position = track.bytes_seen;
				if (b == cfg_now.line_start_byte) begin
					track.phase = PH_LINE_END;
				end else begin
					t.byte_kind = KIND_LINE;
					track.bytes_seen = track.bytes_seen + 8'd1;
					if (track.bytes_seen >= {1'b0, cfg_now.max_line_length}) begin
						t.frame_event = EV_LINEOVF;
						track.phase = PH_IDLE;
					end
				end
			end
			PH_LINE_END: begin
				t.byte_position = track.bytes_seen;
				if (b != cfg_now.line_end_byte) begin
					track.phase = PH_IDLE;
				end else if (track.bytes_seen == 8'd0) begin
					// empty line keeps collecting
					track.phase = PH_LINE;
				end else begin
					t.frame_event = EV_LINE;
					track.phase = PH_IDLE;
				end
			end
			PH_DCMD: begin
				t.byte_kind = KIND_DEBUG;
				t.byte_position = 8'd2;
				t.frame_event = EV_DEBUG;
				track.phase = PH_IDLE;
			end
			default: begin
				// idle: frame header wins over line start, line start over debug header
				if (b == cfg_now.frame_head_first) begin
					t.byte_kind = KIND_FRAME;
					track.running_xor = b;
					track.phase = PH_FHEAD;
				end else if (b == cfg_now.line_start_byte) begin
					track.phase = PH_LSTART;
				end else if (b == cfg_now.debug_head_first) begin
					t.byte_kind = KIND_DEBUG;
					track.phase = PH_DHEAD;
				end else begin
					track.phase = PH_IDLE;
				end
			end
		endcase
		return t;
	endfunction

	// idle length: mostly short, a few long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 70)
			return $urandom_range(2, 1);
		else if (roll < 95)
			return $urandom_range(8, 3);
		else
			return $urandom_range(40, 12);
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
	endtask

	// rx driver: one beat per handshake, random gaps between beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_valid && !rx_stall)
				tags_due.push_back(tag_byte(rx_byte));
			if (!rx_valid || !rx_stall) begin
				if (rx_gap_left != 0) begin
					rx_gap_left--;
					rx_valid <= 1'b0;
				end else if (rx_bytes_q.size() != 0) begin
					rx_valid <= 1'b1;
					rx_byte <= rx_bytes_q.pop_front();
					if (rx_gap_pct != 0 && $urandom_range(99, 0) < rx_gap_pct)
						rx_gap_left = pick_gap();
				end else begin
					rx_valid <= 1'b0;
				end
			end
		end
	end

	// result stall: random holds plus one long hold that fills the block
	always @(posedge clk) begin
		if (res_hold_left != 0) begin
			res_hold_left--;
			res_stall <= 1'b1;
		end else if (long_hold_req && !long_hold_done) begin
			long_hold_done = 1'b1;
			res_hold_left = LONG_HOLD;
			res_stall <= 1'b1;
		end else if (res_stall_pct != 0 && $urandom_range(99, 0) < res_stall_pct) begin
			res_hold_left = pick_gap();
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// result monitor: compare each beat with the oldest expected tag
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			tags_checked++;
			if (tags_due.size() == 0) begin
				report_mismatch("beat with no tag due, echo_byte", echo_byte, 8'd0);
			end else begin
				tag_want = tags_due.pop_front();
				if (echo_byte !== tag_want.echo_byte)
					report_mismatch("echo_byte", echo_byte, tag_want.echo_byte);
				if (byte_kind !== tag_want.byte_kind)
					report_mismatch("byte_kind", {6'd0, byte_kind},
						{6'd0, tag_want.byte_kind});
				if (byte_position !== tag_want.byte_position)
					report_mismatch("byte_position", byte_position, tag_want.byte_position);
				if (frame_event !== tag_want.frame_event)
					report_mismatch("frame_event", {5'd0, frame_event},
						{5'd0, tag_want.frame_event});
			end
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		rx_bytes_q.push_back(b);
		bytes_queued++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FRAME_HEAD_FIRST:  cfg_now.frame_head_first = val;
			REG_FRAME_HEAD_SECOND: cfg_now.frame_head_second = val;
			REG_DEBUG_HEAD_FIRST:  cfg_now.debug_head_first = val;
			REG_DEBUG_HEAD_SECOND: cfg_now.debug_head_second = val;
			REG_LINE_START_BYTE:   cfg_now.line_start_byte = val;
			REG_LINE_END_BYTE:     cfg_now.line_end_byte = val;
			REG_MAX_FRAME_LENGTH:  cfg_now.max_frame_length = val;
			default:               cfg_now.max_line_length = val[6:0];
		endcase
	endtask

	task automatic load_config(input cfg_t c);
		logic top_bit;
		top_bit = 1'($urandom_range(1, 0));
		write_reg(REG_FRAME_HEAD_FIRST, c.frame_head_first);
		write_reg(REG_FRAME_HEAD_SECOND, c.frame_head_second);
		write_reg(REG_DEBUG_HEAD_FIRST, c.debug_head_first);
		write_reg(REG_DEBUG_HEAD_SECOND, c.debug_head_second);
		write_reg(REG_LINE_START_BYTE, c.line_start_byte);
		write_reg(REG_LINE_END_BYTE, c.line_end_byte);
		write_reg(REG_MAX_FRAME_LENGTH, c.max_frame_length);
		// unused top bit of the line limit is set at random
		write_reg(REG_MAX_LINE_LENGTH, {top_bit, c.max_line_length});
	endtask

	// wait until every queued byte has come back tagged
	task automatic settle();
		while (tags_checked < bytes_queued)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// binary frame; body and checksum only when the length passes
	task automatic queue_frame(input int unsigned len, input bit bad_sum);
		logic [7:0] sum, d, lb;
		lb = len[7:0];
		sum = cfg_now.frame_head_first ^ cfg_now.frame_head_second ^ lb;
		queue_byte(cfg_now.frame_head_first);
		queue_byte(cfg_now.frame_head_second);
		queue_byte(lb);
		if (len > MIN_FRAME_LEN && len <= cfg_now.max_frame_length) begin
			for (int unsigned p = 32'(FIRST_BODY_POS); p + 1 < len; p++) begin
				d = 8'($urandom);
				queue_byte(d);
				sum = sum ^ d;
			end
			if (bad_sum)
				sum = sum ^ (8'd1 << $urandom_range(7, 0));
			queue_byte(sum);
		end
	endtask

	// at line: empty, short or up to the limit, sometimes with a broken end pair
	task automatic queue_line();
		int unsigned n, roll, top;
		logic [7:0] d;
		top = 32'(cfg_now.max_line_length);
		roll = $urandom_range(99, 0);
		if (roll < 10)
			n = 0;
		else if (roll < 25)
			n = $urandom_range(top, 1);
		else
			n = $urandom_range(top < 8 ? top : 8, 1);
		queue_byte(cfg_now.line_start_byte);
		queue_byte(cfg_now.line_end_byte);
		repeat (n) begin
			d = 8'($urandom);
			if (d == cfg_now.line_start_byte)
				d = d ^ 8'h01;
			queue_byte(d);
		end
		queue_byte(cfg_now.line_start_byte);
		if (roll >= 90) begin
			d = 8'($urandom);
			if (d == cfg_now.line_end_byte)
				d = ~d;
			queue_byte(d);
		end else begin
			queue_byte(cfg_now.line_end_byte);
		end
	endtask

	// mixed traffic: mostly well-formed sequences, some noise and broken starts
	task automatic build_traffic(input int unsigned n);
		int unsigned first, roll, pick, top, len;
		logic [7:0] d;
		first = bytes_queued;
		while (bytes_queued - first < n) begin
			roll = $urandom_range(99, 0);
			top = 32'(cfg_now.max_frame_length);
			if (roll < 35) begin
				pick = $urandom_range(99, 0);
				if (pick < 8) begin
					if (top < 255 && $urandom_range(1, 0))
						len = $urandom_range(255, top + 1);
					else
						len = $urandom_range(2, 0);
				end else if (pick < 11) begin
					len = $urandom_range(top, 3);
				end else begin
					len = $urandom_range(top < 12 ? top : 12, 3);
				end
				queue_frame(len, $urandom_range(9, 0) == 0);
			end else if (roll < 60) begin
				queue_line();
			end else if (roll < 75) begin
				queue_byte(cfg_now.debug_head_first);
				queue_byte(cfg_now.debug_head_second);
				queue_byte(8'($urandom));
			end else if (roll < 88) begin
				repeat ($urandom_range(4, 1)) queue_byte(8'($urandom));
			end else begin
				d = 8'($urandom);
				case ($urandom_range(2, 0))
					0: begin
						queue_byte(cfg_now.frame_head_first);
						queue_byte(d == cfg_now.frame_head_second ? ~d : d);
					end
					1: begin
						queue_byte(cfg_now.line_start_byte);
						queue_byte(d == cfg_now.line_end_byte ? ~d : d);
					end
					default: begin
						queue_byte(cfg_now.debug_head_first);
						queue_byte(d == cfg_now.debug_head_second ? ~d : d);
					end
				endcase
			end
		end
	endtask

	function automatic cfg_t phase_config(input int k);
		cfg_t c;
		c.frame_head_first = 8'($urandom);
		c.frame_head_second = 8'($urandom);
		c.debug_head_first = 8'($urandom);
		c.debug_head_second = 8'($urandom);
		c.line_start_byte = 8'($urandom);
		c.line_end_byte = 8'($urandom);
		c.max_frame_length = 8'($urandom_range(255, 3));
		c.max_line_length = 7'($urandom_range(127, 1));
		case (k)
			0: begin
				c.max_frame_length = 8'd255;
				c.max_line_length = 7'd127;
			end
			1: begin
				// tightest limits; header pair xors to three so a shortest frame can pass
				c.frame_head_first = 8'h00;
				c.frame_head_second = 8'h03;
				c.debug_head_first = 8'hFF;
				c.debug_head_second = 8'h00;
				c.max_frame_length = MIN_FRAME_LEN;
				c.max_line_length = 7'd1;
			end
			2: begin
				// all three start bytes equal
				c.line_start_byte = c.frame_head_first;
				c.debug_head_first = c.frame_head_first;
			end
			3: c.debug_head_first = c.line_start_byte;
			default: ;
		endcase
		return c;
	endfunction

	initial begin
		cfg_t c;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: zero headers give a length four frame
		rx_gap_pct = 20;
		res_stall_pct = 20;
		queue_byte(8'h00);
		queue_byte(8'h00);
		queue_byte(8'h04);
		queue_byte(8'h04);
		settle();

		// directed cases
		c = '{8'hAA, 8'h55, 8'hD0, 8'h3C, RST_LINE_START, RST_LINE_END,
			RST_MAX_FRAME, RST_MAX_LINE};
		load_config(c);
		queue_frame(4, 1'b0);
		queue_frame(4, 1'b1);
		queue_frame(2, 1'b0);
		queue_frame(255, 1'b0);
		// wrong second header byte
		queue_byte(8'hAA);
		queue_byte(8'h00);
		// empty line, then a one byte line
		queue_byte(RST_LINE_START);
		queue_byte(RST_LINE_END);
		queue_byte(RST_LINE_START);
		queue_byte(RST_LINE_END);
		queue_byte(8'h41);
		queue_byte(RST_LINE_START);
		queue_byte(RST_LINE_END);
		// delimiter pair broken inside a line
		queue_byte(RST_LINE_START);
		queue_byte(RST_LINE_END);
		queue_byte(8'h41);
		queue_byte(RST_LINE_START);
		queue_byte(8'h42);
		// debug command
		queue_byte(8'hD0);
		queue_byte(8'h3C);
		queue_byte(8'hFF);
		settle();

		// random phases, each under its own register setting
		for (int k = 0; k < PHASE_COUNT; k++) begin
			c = phase_config(k);
			load_config(c);
			rx_gap_pct = gap_plan[k];
			res_stall_pct = stall_plan[k];
			if (k == 4)
				long_hold_req = 1'b1;
			build_traffic(PHASE_BYTES);
			settle();
		end

		if (tags_due.size() != 0)
			report_mismatch("tags left over, echo_byte", 8'd0, tags_due[0].echo_byte);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### files.f
src/sfcp_pkg.sv
src/sfcp_step.sv
src/serial_frame_and_command_parser.sv
bench/serial_frame_and_command_parser_tb.sv
